// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define TSE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// shared types and constants of the topological sort engine
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int NODE_W = 6;
  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_NODE = 2'd0,
    FUNC_ADD_DEP  = 2'd1,
    FUNC_SORT     = 2'd2,
    FUNC_CLEAR    = 2'd3
  } tse_func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_LOOP,
    ST_Q_RD,
    ST_Q_WAIT,
    ST_ROW_RD,
    ST_DEP_SCAN,
    ST_DEP_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_STATUS
  } tse_state_t;

  // graph store control
  typedef struct packed {
    logic clear;
    logic mark_a;
    logic mark_b;
    logic edge_wr;
  } tse_gctl_t;

endpackage

// ===== hdl/tse_ram.sv =====
// ----------------------------------------------------------------------------
// tse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/tse_graph.sv =====
// ----------------------------------------------------------------------------
// tse_graph
// graph store: edge rows and in-degrees in ram, row and entry valid bits,
// present mask
// ----------------------------------------------------------------------------
module tse_graph import tse_pkg::*; #(
  parameter int MAX_NODES = 64,
  localparam int NW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tse_gctl_t            gctl,
  input  logic [NW-1:0]        addr_a,
  input  logic [NW-1:0]        addr_b,
  input  logic [MAX_NODES-1:0] row_wr_data,
  input  logic [CW-1:0]        deg_wr_data,
  input  logic [NW-1:0]        row_rd_addr,
  input  logic [NW-1:0]        deg_rd_addr,
  output logic [MAX_NODES-1:0] row_rd_data,
  output logic [CW-1:0]        deg_rd_data,
  output logic [MAX_NODES-1:0] present
);

  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] deg_valid;
  logic                 row_hit;
  logic                 deg_hit;
  logic [MAX_NODES-1:0] row_ram;
  logic [CW-1:0]        deg_ram;

  tse_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_rows (
    .clk     (clk),
    .wr_en   (gctl.edge_wr),
    .wr_addr (addr_b),
    .wr_data (row_wr_data),
    .rd_addr (row_rd_addr),
    .rd_data (row_ram)
  );

  tse_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_deg (
    .clk     (clk),
    .wr_en   (gctl.edge_wr),
    .wr_addr (addr_a),
    .wr_data (deg_wr_data),
    .rd_addr (deg_rd_addr),
    .rd_data (deg_ram)
  );

  always_ff @(posedge clk) begin
    if (rst || gctl.clear) begin
      row_valid <= '0;
      deg_valid <= '0;
      present   <= '0;
      row_hit   <= 1'b0;
      deg_hit   <= 1'b0;
    end else begin
      row_hit <= row_valid[row_rd_addr];
      deg_hit <= deg_valid[deg_rd_addr];
      if (gctl.mark_a) begin
        present[addr_a] <= 1'b1;
      end
      if (gctl.mark_b) begin
        present[addr_b] <= 1'b1;
      end
      if (gctl.edge_wr) begin
        row_valid[addr_b] <= 1'b1;
        deg_valid[addr_a] <= 1'b1;
      end
    end
  end

  // entries never written read as zero
  assign row_rd_data = row_hit ? row_ram : '0;
  assign deg_rd_data = deg_hit ? deg_ram : '0;

endmodule

// ===== hdl/tse_kahn.sv =====
// ----------------------------------------------------------------------------
// tse_kahn
// sequencer: graph loads, kahn ordering over work and queue rams, result
// register
// ----------------------------------------------------------------------------
module tse_kahn import tse_pkg::*; #(
  parameter int MAX_NODES = 64,
  localparam int NW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [NODE_W-1:0]    node_a,
  input  logic [NODE_W-1:0]    node_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NODE_W-1:0]    node_out,
  output logic                 has_node,
  output logic                 cycle_found,
  output logic                 last,
  output tse_gctl_t            gctl,
  output logic [NW-1:0]        g_addr_a,
  output logic [NW-1:0]        g_addr_b,
  output logic [MAX_NODES-1:0] g_row_wr_data,
  output logic [CW-1:0]        g_deg_wr_data,
  output logic [NW-1:0]        g_row_rd_addr,
  output logic [NW-1:0]        g_deg_rd_addr,
  input  logic [MAX_NODES-1:0] g_row_rd_data,
  input  logic [CW-1:0]        g_deg_rd_data,
  input  logic [MAX_NODES-1:0] g_present
);

  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

  tse_state_t    state, state_next;
  logic [NW-1:0] a_q, a_q_next;
  logic [NW-1:0] b_q, b_q_next;
  logic [NW-1:0] scan, scan_next;
  logic [NW-1:0] cur, cur_next;
  logic [CW-1:0] head, head_next;
  logic [CW-1:0] tail, tail_next;
  logic [CW-1:0] present_cnt, present_cnt_next;
  logic          status_cyc, status_cyc_next;

  logic [NW-1:0] in_a;
  logic [NW-1:0] in_b;
  logic          a_ok;
  logic          b_ok;
  logic          out_free;
  logic          out_load;
  logic [NODE_W-1:0] load_node;
  logic          load_has;
  logic          load_cyc;
  logic          load_last;

  logic          q_wr_en;
  logic [NW-1:0] q_rd_addr;
  logic [NW-1:0] q_rd_data;
  logic          w_wr_en;
  logic [CW-1:0] w_wr_data;
  logic [CW-1:0] w_rd_data;

  assign in_a = NW'(node_a);
  assign in_b = NW'(node_b);
  assign a_ok = 32'(node_a) < MAX_NODES;
  assign b_ok = 32'(node_b) < MAX_NODES;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // graph addressing
  assign g_addr_a      = (state == ST_IDLE) ? in_a : a_q;
  assign g_addr_b      = (state == ST_IDLE) ? in_b : b_q;
  assign g_row_rd_addr = (state == ST_IDLE) ? in_b : cur;
  assign g_deg_rd_addr = (state == ST_IDLE) ? in_a : scan;
  assign g_row_wr_data = g_row_rd_data | (MAX_NODES'(1) << a_q);
  assign g_deg_wr_data = g_deg_rd_data + CW'(1);

  assign q_rd_addr = (state == ST_EMIT_RD || state == ST_EMIT_LD) ? scan : head[NW-1:0];

  // ready queue, written at tail
  tse_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (tail[NW-1:0]),
    .wr_data (scan),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  // working in-degrees
  tse_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_work (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (scan),
    .wr_data (w_wr_data),
    .rd_addr (scan),
    .rd_data (w_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_q         <= a_q_next;
    b_q         <= b_q_next;
    scan        <= scan_next;
    cur         <= cur_next;
    head        <= head_next;
    tail        <= tail_next;
    present_cnt <= present_cnt_next;
    status_cyc  <= status_cyc_next;
    if (out_load) begin
      node_out    <= load_node;
      has_node    <= load_has;
      cycle_found <= load_cyc;
      last        <= load_last;
    end
  end

  always_comb begin
    state_next       = state;
    a_q_next         = a_q;
    b_q_next         = b_q;
    scan_next        = scan;
    cur_next         = cur;
    head_next        = head;
    tail_next        = tail;
    present_cnt_next = present_cnt;
    status_cyc_next  = status_cyc;
    gctl             = '0;
    q_wr_en          = 1'b0;
    w_wr_en          = 1'b0;
    w_wr_data        = g_deg_rd_data;
    out_load         = 1'b0;
    load_node        = '0;
    load_has         = 1'b0;
    load_cyc         = 1'b0;
    load_last        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (tse_func_t'(func))
            FUNC_ADD_NODE: begin
              gctl.mark_a = a_ok;
            end
            FUNC_ADD_DEP: begin
              if (a_ok && b_ok) begin
                gctl.mark_a = 1'b1;
                gctl.mark_b = 1'b1;
                a_q_next    = in_a;
                b_q_next    = in_b;
                state_next  = ST_EDGE_WR;
              end
            end
            FUNC_SORT: begin
              scan_next        = '0;
              head_next        = '0;
              tail_next        = '0;
              present_cnt_next = '0;
              state_next       = ST_INIT_RD;
            end
            default: begin
              gctl.clear = 1'b1;
            end
          endcase
        end
      end

      // duplicate edges leave row and in-degree alone
      ST_EDGE_WR: begin
        gctl.edge_wr = !g_row_rd_data[a_q];
        state_next   = ST_IDLE;
      end

      ST_INIT_RD: begin
        state_next = ST_INIT_WR;
      end

      ST_INIT_WR: begin
        w_wr_en = 1'b1;
        if (g_present[scan]) begin
          present_cnt_next = present_cnt + CW'(1);
          if (g_deg_rd_data == '0) begin
            q_wr_en   = 1'b1;
            tail_next = tail + CW'(1);
          end
        end
        if (scan == LAST_IDX) begin
          state_next = ST_LOOP;
        end else begin
          scan_next  = scan + NW'(1);
          state_next = ST_INIT_RD;
        end
      end

      ST_LOOP: begin
        if (head != tail) begin
          state_next = ST_Q_RD;
        end else if (present_cnt == '0) begin
          status_cyc_next = 1'b0;
          state_next      = ST_STATUS;
        end else if (tail != present_cnt) begin
          status_cyc_next = 1'b1;
          state_next      = ST_STATUS;
        end else begin
          scan_next  = '0;
          state_next = ST_EMIT_RD;
        end
      end

      ST_Q_RD: begin
        state_next = ST_Q_WAIT;
      end

      ST_Q_WAIT: begin
        cur_next   = q_rd_data;
        head_next  = head + CW'(1);
        state_next = ST_ROW_RD;
      end

      ST_ROW_RD: begin
        scan_next  = '0;
        state_next = ST_DEP_SCAN;
      end

      ST_DEP_SCAN: begin
        if (g_row_rd_data[scan]) begin
          state_next = ST_DEP_WR;
        end else if (scan == LAST_IDX) begin
          state_next = ST_LOOP;
        end else begin
          scan_next = scan + NW'(1);
        end
      end

      ST_DEP_WR: begin
        if (w_rd_data != '0) begin
          w_wr_en   = 1'b1;
          w_wr_data = w_rd_data - CW'(1);
          if (w_rd_data == CW'(1)) begin
            q_wr_en   = 1'b1;
            tail_next = tail + CW'(1);
          end
        end
        if (scan == LAST_IDX) begin
          state_next = ST_LOOP;
        end else begin
          scan_next  = scan + NW'(1);
          state_next = ST_DEP_SCAN;
        end
      end

      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_node = NODE_W'(q_rd_data);
          load_has  = 1'b1;
          load_last = (CW'(scan) + CW'(1)) == tail;
          if (load_last) begin
            state_next = ST_IDLE;
          end else begin
            scan_next  = scan + NW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_cyc   = status_cyc;
          load_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/topological_sort_engine_top.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine_top
// dependency graph store with kahn topological ordering
// ----------------------------------------------------------------------------
// Add-node and clear transfers complete in the idle state; add-dependency reads
// the row in idle, then writes row and in-degree in the edge write state. A
// sort holds in_stall high through the in-degree copy, the queue pops with
// their edge row walks and work-degree read-modify-writes, and the emission of
// the node results or the single status result, until the last result is
// loaded into the result register, so any output stall lengthens it. The
// single sequencer steps node indices through the ram read ports.
// Graph memories need no clearing pass; per-row valid bits make reset and
// clear take effect at once.
module topological_sort_engine_top import tse_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] node_out,
  output logic              has_node,
  output logic              cycle_found,
  output logic              last
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  // sequencer to graph store
  tse_gctl_t            gctl;
  logic [NW-1:0]        g_addr_a;
  logic [NW-1:0]        g_addr_b;
  logic [MAX_NODES-1:0] g_row_wr_data;
  logic [CW-1:0]        g_deg_wr_data;
  logic [NW-1:0]        g_row_rd_addr;
  logic [NW-1:0]        g_deg_rd_addr;
  // graph store to sequencer
  logic [MAX_NODES-1:0] g_row_rd_data;
  logic [CW-1:0]        g_deg_rd_data;
  logic [MAX_NODES-1:0] g_present;

  // edge rows, in-degrees and present mask
  tse_graph #(.MAX_NODES(MAX_NODES)) u_graph (
    .clk         (clk),
    .rst         (rst),
    .gctl        (gctl),
    .addr_a      (g_addr_a),
    .addr_b      (g_addr_b),
    .row_wr_data (g_row_wr_data),
    .deg_wr_data (g_deg_wr_data),
    .row_rd_addr (g_row_rd_addr),
    .deg_rd_addr (g_deg_rd_addr),
    .row_rd_data (g_row_rd_data),
    .deg_rd_data (g_deg_rd_data),
    .present     (g_present)
  );

  // load handling, ordering sequencer and result register
  tse_kahn #(.MAX_NODES(MAX_NODES)) u_kahn (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .node_a        (node_a),
    .node_b        (node_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .node_out      (node_out),
    .has_node      (has_node),
    .cycle_found   (cycle_found),
    .last          (last),
    .gctl          (gctl),
    .g_addr_a      (g_addr_a),
    .g_addr_b      (g_addr_b),
    .g_row_wr_data (g_row_wr_data),
    .g_deg_wr_data (g_deg_wr_data),
    .g_row_rd_addr (g_row_rd_addr),
    .g_deg_rd_addr (g_deg_rd_addr),
    .g_row_rd_data (g_row_rd_data),
    .g_deg_rd_data (g_deg_rd_data),
    .g_present     (g_present)
  );

endmodule

// ===== hdl/tse_checker.sv =====
// ----------------------------------------------------------------------------
// tse_checker
// port level checks of the topological sort engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tse_checker import tse_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [FUNC_W-1:0] func,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] node_out,
  input logic              has_node,
  input logic              cycle_found,
  input logic              last
);

  // a held result stays valid and keeps its node and last flag
  `TSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(node_out) && $stable(last), "result changed while stalled")

  // a node result never also reports a cycle
  `TSE_ASSERT_ALWAYS(a_node_xor_cycle, !(out_valid && has_node && cycle_found), "node result flagged as cycle")

  // status results close the run and carry node zero
  `TSE_ASSERT_ALWAYS(a_status_last, !(out_valid && !has_node) || (last && node_out == '0), "status result not final")

  // in_stall is high in the cycle after a sort transfer is taken
  `TSE_ASSERT_NEXT(a_sort_busy, in_valid && !in_stall && func == FUNC_SORT, in_stall, "engine ready straight after sort")

endmodule

bind topological_sort_engine_top tse_checker u_tse_checker (.*);
